>>> design/sihs_pkg.sv
// Package for the small integer histogram store.
// Holds table sizing, request and state codes, controller/datapath structs
// and the saturating count helpers. No dependencies.
`timescale 1ns / 1ps

package sihs_pkg;

  localparam int TABLE_DEPTH = 16384;
  localparam int COUNT_BITS  = 32;
  localparam int SLOT_BITS   = $clog2(TABLE_DEPTH);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX    = '1;
  localparam logic [14:0]           DISTINCT_MAX = 15'h7fff;

  localparam logic signed [15:0] VALUE_LOW_RESET  = -16'sd5000;
  localparam logic signed [15:0] VALUE_HIGH_RESET = 16'sd5000;

  // Configuration register indexes.
  localparam logic CFG_VALUE_LOW  = 1'b0;
  localparam logic CFG_VALUE_HIGH = 1'b1;

  typedef enum logic [2:0] {
    REQ_ADD    = 3'd0,
    REQ_QUERY  = 3'd1,
    REQ_SELECT = 3'd2,
    REQ_MERGE  = 3'd3,
    REQ_CLEAR  = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_MODIFY,
    ST_SELECT,
    ST_CLEAR
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;      // capture a request and read its slot
    logic modify;      // finish a read-modify-write request
    logic sel_step;    // one step of the select walk
    logic sel_finish;  // select result is ready
    logic clr_step;    // write zero at the clear cursor
    logic clr_finish;  // last clear write, report the result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;    // clear cursor sits on the last slot
    logic sel_done;    // select walk has a hit or ran out of slots
  } status_t;

  // Saturating add of an external count into a table counter.
  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                    input logic [31:0] b);
    logic [64:0] sum;
    sum = 65'(a) + 65'(b);
    if (sum > 65'(COUNT_MAX)) begin
      return COUNT_MAX;
    end
    return sum[COUNT_BITS-1:0];
  endfunction

  // Low 32 bits of a counter, zero extended when the counter is narrower.
  function automatic logic [31:0] low_count(input logic [COUNT_BITS-1:0] c);
    logic [63:0] w;
    w = 64'(c);
    return w[31:0];
  endfunction

endpackage

>>> design/small_int_histogram_store.sv
// Top level of the small integer histogram store.
// Joins the controller (sihs_ctrl) and the datapath (sihs_datapath).
// Depends on sihs_pkg.
`timescale 1ns / 1ps

// The block keeps one saturating counter per storable whole number in a
// 16384-entry table memory and answers one request per transfer.
// A request transfers at a rising edge with start high and busy low; the
// request code and all payload fields are sampled at that edge.
// Exactly one result follows each request: out_valid is high for one cycle
// and the result fields are valid in that cycle. The receiver cannot stall,
// so the result is simply taken at the edge ending that cycle.
// Add, query, merge and unknown codes pass through idle and modify: the accept
// cycle reads the slot and the next cycle writes back an accepted add or merge.
// The result strobe rises in the cycle after that, while the block is already
// able to take a new request; each such request reads the table once.
// Select walks the table one slot per cycle through the read port and stays
// busy until the rank is hit or every slot has been read.
// Clear sweeps the table one slot per cycle through the write port and is
// busy until the last slot has been written.
// After reset the same sweep runs: busy stays high while the table is zeroed.
// Configuration writes on cfg_we are taken at any edge, including during that
// sweep, and apply immediately.

module small_int_histogram_store
  import sihs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic        [2:0]  in_req_type,
  input  logic signed [31:0] in_value,
  input  logic               in_value_is_whole,
  input  logic        [13:0] in_rank,
  input  logic        [13:0] in_merge_slot,
  input  logic        [31:0] in_merge_count,
  output logic               out_valid,
  output logic               out_accepted,
  output logic               out_first_seen,
  output logic        [31:0] out_count,
  output logic               out_found,
  output logic signed [16:0] out_selected_value,
  output logic        [14:0] out_distinct_total,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic        [15:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  // The controller only sequences; all storage and arithmetic live below.
  sihs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_req_type),
    .status   (status),
    .busy     (busy),
    .cmd      (cmd)
  );

  sihs_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_req_type        (in_req_type),
    .in_value           (in_value),
    .in_value_is_whole  (in_value_is_whole),
    .in_rank            (in_rank),
    .in_merge_slot      (in_merge_slot),
    .in_merge_count     (in_merge_count),
    .out_valid          (out_valid),
    .out_accepted       (out_accepted),
    .out_first_seen     (out_first_seen),
    .out_count          (out_count),
    .out_found          (out_found),
    .out_selected_value (out_selected_value),
    .out_distinct_total (out_distinct_total)
  );

  // Results are never reported back to back, so out_valid always drops after a strobe.
  a_single_strobe : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // Every accepted request keeps the block busy in the following cycle.
  a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after a request transfer");

  // A rejected request reports no count and no first sighting.
  a_reject_clean : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_accepted) |-> (!out_first_seen && (out_count == 32'd0)))
    else $error("rejected request reports a count or first sighting");

  // A first sighting always leaves a nonzero count and a nonzero distinct total.
  a_first_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_first_seen) |-> ((out_count != 32'd0) && (out_distinct_total != 15'd0)))
    else $error("first sighting with zero count or zero distinct total");

  // A select hit is always reported as accepted.
  a_found_accepted : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> out_accepted)
    else $error("select hit not marked accepted");

endmodule

>>> design/sihs_ctrl.sv
// Controller state machine of the small integer histogram store.
// Sequences request accept, read-modify-write, select walk and clear sweep.
// Depends on sihs_pkg.
`timescale 1ns / 1ps

module sihs_ctrl
  import sihs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [2:0] req_type,
  input  status_t    status,
  output logic       busy,
  output cmd_t       cmd
);

  state_t state_r, state_nxt;
  logic   accept;
  req_t   req;

  assign accept = start && (state_r == ST_IDLE);
  assign req    = req_t'(req_type);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (status.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (req)
            REQ_SELECT: state_nxt = ST_SELECT;
            REQ_CLEAR:  state_nxt = ST_CLEAR;
            default:    state_nxt = ST_MODIFY;
          endcase
        end
      end
      ST_MODIFY: state_nxt = ST_IDLE;
      ST_SELECT: begin
        if (status.sel_done) state_nxt = ST_IDLE;
      end
      ST_CLEAR: begin
        if (status.clr_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_INIT: begin
        cmd.clr_step = 1'b1;
      end
      ST_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
      end
      ST_MODIFY: begin
        cmd.modify = 1'b1;
      end
      ST_SELECT: begin
        cmd.sel_step   = 1'b1;
        cmd.sel_finish = status.sel_done;
      end
      ST_CLEAR: begin
        cmd.clr_step   = 1'b1;
        cmd.clr_finish = status.clr_last;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

>>> design/sihs_datapath.sv
// Datapath of the small integer histogram store: count table memory,
// configuration registers, request registers, select walk and result registers.
// Depends on sihs_pkg.
`timescale 1ns / 1ps

module sihs_datapath
  import sihs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic        [15:0] cfg_data,
  input  logic        [2:0]  in_req_type,
  input  logic signed [31:0] in_value,
  input  logic               in_value_is_whole,
  input  logic        [13:0] in_rank,
  input  logic        [13:0] in_merge_slot,
  input  logic        [31:0] in_merge_count,
  output logic               out_valid,
  output logic               out_accepted,
  output logic               out_first_seen,
  output logic        [31:0] out_count,
  output logic               out_found,
  output logic signed [16:0] out_selected_value,
  output logic        [14:0] out_distinct_total
);

  logic [COUNT_BITS-1:0] count_table_mem [TABLE_DEPTH];

  logic signed [15:0] value_low_r, value_high_r;
  logic        [14:0] distinct_r, distinct_nxt;

  req_t                  req_r;
  logic                  ok_r;
  logic [SLOT_BITS-1:0]  slot_r;
  logic [31:0]           mcount_r;
  logic [13:0]           rank_r;
  logic [COUNT_BITS-1:0] rdata_r;

  logic [SLOT_BITS-1:0]  clr_r;
  logic [SLOT_BITS-1:0]  scan_r;
  logic                  scan_busy_r;
  logic [SLOT_BITS-1:0]  data_slot_r;
  logic                  data_ok_r;
  logic [SLOT_BITS:0]    passed_r;

  logic                  out_valid_r;
  logic                  out_accepted_r, out_first_r, out_found_r;
  logic [31:0]           out_count_r;
  logic signed [16:0]    out_sel_r;
  logic [14:0]           out_distinct_r;

  // Accept-side address mapping.
  logic signed [32:0]    v_ext, lo_ext, hi_ext, diff;
  logic                  storable, merge_ok, acc_ok;
  logic [31:0]           mslot_ext;
  logic [SLOT_BITS-1:0]  acc_slot;
  req_t                  in_req;

  assign in_req    = req_t'(in_req_type);
  assign v_ext     = 33'(in_value);
  assign lo_ext    = 33'(value_low_r);
  assign hi_ext    = 33'(value_high_r);
  assign diff      = v_ext - lo_ext;
  assign storable  = in_value_is_whole && (v_ext >= lo_ext) && (v_ext <= hi_ext) &&
                     (diff < 33'(TABLE_DEPTH));
  assign mslot_ext = 32'(in_merge_slot);
  assign merge_ok  = mslot_ext < 32'(TABLE_DEPTH);

  always_comb begin
    acc_ok   = 1'b0;
    acc_slot = diff[SLOT_BITS-1:0];
    unique case (in_req) inside
      REQ_ADD, REQ_QUERY: acc_ok = storable;
      REQ_MERGE: begin
        acc_ok   = merge_ok;
        acc_slot = mslot_ext[SLOT_BITS-1:0];
      end
      default: acc_ok = 1'b0;
    endcase
  end

  // Read-modify-write arithmetic.
  logic                  is_bump, first, mod_we;
  logic [COUNT_BITS-1:0] new_cnt;

  assign is_bump = (req_r == REQ_ADD) || (req_r == REQ_MERGE);
  assign new_cnt = sat_add(rdata_r, (req_r == REQ_ADD) ? 32'd1 : mcount_r);
  assign first   = ok_r && is_bump && (rdata_r == '0) && (new_cnt != '0);
  assign mod_we  = cmd.modify && ok_r && is_bump;

  always_comb begin
    distinct_nxt = distinct_r;
    if (cmd.modify && first && (distinct_r < DISTINCT_MAX)) begin
      distinct_nxt = distinct_r + 15'd1;
    end
  end

  // Select walk evaluation on the registered read data.
  logic sel_hit, sel_nonzero;

  assign sel_nonzero = data_ok_r && (rdata_r != '0);
  assign sel_hit     = sel_nonzero && (32'(passed_r) == 32'(rank_r));

  assign status.sel_done = sel_hit || !scan_busy_r;
  assign status.clr_last = (clr_r == SLOT_BITS'(TABLE_DEPTH - 1));

  // Memory ports: one read address, one write address per cycle.
  logic                  scan_issue, mem_re, mem_we;
  logic [SLOT_BITS-1:0]  rd_addr, wr_addr;
  logic [COUNT_BITS-1:0] wr_data;

  assign scan_issue = cmd.sel_step && scan_busy_r;
  assign mem_re     = cmd.accept || scan_issue;
  assign rd_addr    = scan_issue ? scan_r : acc_slot;
  assign mem_we     = cmd.clr_step || mod_we;
  assign wr_addr    = cmd.clr_step ? clr_r : slot_r;
  assign wr_data    = cmd.clr_step ? '0 : new_cnt;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      count_table_mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rdata_r <= count_table_mem[rd_addr];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_low_r  <= VALUE_LOW_RESET;
      value_high_r <= VALUE_HIGH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VALUE_LOW:  value_low_r  <= cfg_data;
        CFG_VALUE_HIGH: value_high_r <= cfg_data;
      endcase
    end
  end

  // Request payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r    <= in_req;
      ok_r     <= acc_ok;
      slot_r   <= acc_slot;
      mcount_r <= in_merge_count;
      rank_r   <= in_rank;
    end
    if (scan_issue) begin
      data_slot_r <= scan_r;
    end
  end

  // Control counters and flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      distinct_r  <= '0;
      clr_r       <= '0;
      scan_r      <= '0;
      scan_busy_r <= 1'b0;
      data_ok_r   <= 1'b0;
      passed_r    <= '0;
    end else begin
      if (cmd.clr_finish) begin
        distinct_r <= '0;
      end else begin
        distinct_r <= distinct_nxt;
      end

      if (cmd.accept) begin
        clr_r <= '0;
      end else if (cmd.clr_step) begin
        clr_r <= clr_r + SLOT_BITS'(1);
      end

      if (cmd.accept) begin
        scan_r      <= '0;
        scan_busy_r <= 1'b1;
        data_ok_r   <= 1'b0;
        passed_r    <= '0;
      end else if (cmd.sel_step) begin
        data_ok_r <= scan_issue;
        if (scan_issue) begin
          scan_r <= scan_r + SLOT_BITS'(1);
          if (scan_r == SLOT_BITS'(TABLE_DEPTH - 1)) begin
            scan_busy_r <= 1'b0;
          end
        end
        if (sel_nonzero && !sel_hit) begin
          passed_r <= passed_r + (SLOT_BITS + 1)'(1);
        end
      end
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.modify || cmd.sel_finish || cmd.clr_finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.modify) begin
      out_accepted_r <= ok_r;
      out_first_r    <= first;
      out_found_r    <= 1'b0;
      out_sel_r      <= '0;
      out_distinct_r <= distinct_nxt;
      if (!ok_r) begin
        out_count_r <= '0;
      end else if (is_bump) begin
        out_count_r <= low_count(new_cnt);
      end else if (req_r == REQ_QUERY) begin
        out_count_r <= low_count(rdata_r);
      end else begin
        out_count_r <= '0;
      end
    end else if (cmd.sel_finish) begin
      out_accepted_r <= sel_hit;
      out_first_r    <= 1'b0;
      out_count_r    <= '0;
      out_found_r    <= sel_hit;
      out_sel_r      <= sel_hit ? (17'(data_slot_r) + 17'(value_low_r)) : '0;
      out_distinct_r <= distinct_r;
    end else if (cmd.clr_finish) begin
      out_accepted_r <= 1'b1;
      out_first_r    <= 1'b0;
      out_count_r    <= '0;
      out_found_r    <= 1'b0;
      out_sel_r      <= '0;
      out_distinct_r <= '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_accepted       = out_accepted_r;
  assign out_first_seen     = out_first_r;
  assign out_count          = out_count_r;
  assign out_found          = out_found_r;
  assign out_selected_value = out_sel_r;
  assign out_distinct_total = out_distinct_r;

endmodule
